// ===== rtl/bbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the block buffer cache tag manager.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int unsigned NumBuffers = 32;
  localparam int unsigned NumDevices = 16;
  localparam int unsigned RefBits    = 8;

  localparam int unsigned FuncW   = 2;
  localparam int unsigned DevW    = 4;
  localparam int unsigned BlockW  = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic [FuncW-1:0] {
    FUNC_GET     = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_DIRTY   = 2'd2,
    FUNC_FLUSH   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_NOBUF   = 2'd1,
    ST_UNREF   = 2'd2,
    ST_UNUSED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESULT,
    S_FLUSH,
    S_FLUSH_OUT,
    S_CLOSE
  } state_e;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [DevW-1:0]   dev;
    logic [BlockW-1:0] block_number;
    logic [IdxW-1:0]   entry_index;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [IdxW-1:0]    entry_index_out;
    logic               hit;
    logic               need_read;
    logic               write_back;
    logic [DevW-1:0]    dev_out;
    logic [BlockW-1:0]  block_out;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic scan;       // evaluate lookup and victim search
    logic apply;      // update entry state, build result
    logic flush_find; // find next flushable entry at or above cursor
    logic flush_take; // emit and clean found entry
    logic close;      // build closing item
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic flush_found;
  } sts_t;

endpackage

// ===== rtl/bbc_if.sv =====
// ----------------------------------------------------------------------------
// bbc_if
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
interface bbc_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/block_buffer_cache_lru.sv =====
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Fully associative buffer cache tag manager with reference counts and LRU.
// ----------------------------------------------------------------------------
// Requests enter on req (func, dev, block_number, entry_index); results leave
// on rsp, each marked last on the final item of its request.
// One request is in flight at a time. Get, release and mark dirty take
// their steps in order after accept (compare all tags and pick the least
// recent free entry, update, present the result), then return to accept
// once the receiver has taken the result item.
// Flush walks the entries from the lowest index: each listed entry is
// searched from the cursor and presented, then one closing item with last
// set. The single result register holds its item while the receiver stalls,
// and no request is taken until the last item has gone.
// Reset clears all tags, marks and counts at once and sets the recency order
// to entry index, entry zero least recent; the block is ready in the first
// cycle after reset.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru #(
  parameter int unsigned NUM_BUFFERS = bbc_pkg::NumBuffers,
  parameter int unsigned NUM_DEVICES = bbc_pkg::NumDevices,
  parameter int unsigned REF_BITS    = bbc_pkg::RefBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  bbc_if.sink  req,
  bbc_if.source rsp
);

  bbc_pkg::cmd_t cmd;
  bbc_pkg::sts_t sts;
  bbc_pkg::rsp_t rsp_data;

  bbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bbc_datapath #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .NUM_DEVICES (NUM_DEVICES),
    .REF_BITS    (REF_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req.data),
    .sts_o  (sts),
    .rsp_o  (rsp_data)
  );

  assign rsp.data = rsp_data;

endmodule

// ===== rtl/bbc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbc_ctrl
// Sequencer for request handling, result hand-off and flush walk.
// ----------------------------------------------------------------------------
module bbc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bbc_pkg::sts_t sts_i,
  output bbc_pkg::cmd_t cmd_o
);

  bbc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      bbc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bbc_pkg::S_SCAN;
        end
      end
      bbc_pkg::S_SCAN: begin
        if (sts_i.is_flush) begin
          cmd_o.flush_find = 1'b1;
          state_d          = bbc_pkg::S_FLUSH;
        end else begin
          cmd_o.scan = 1'b1;
          state_d    = bbc_pkg::S_APPLY;
        end
      end
      bbc_pkg::S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = bbc_pkg::S_RESULT;
      end
      bbc_pkg::S_RESULT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = bbc_pkg::S_IDLE;
        end
      end
      bbc_pkg::S_FLUSH: begin
        if (sts_i.flush_found) begin
          cmd_o.flush_take = 1'b1;
          state_d          = bbc_pkg::S_FLUSH_OUT;
        end else begin
          cmd_o.close = 1'b1;
          state_d     = bbc_pkg::S_RESULT;
        end
      end
      bbc_pkg::S_FLUSH_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.flush_find = 1'b1;
          state_d          = bbc_pkg::S_FLUSH;
        end
      end
      default: begin
        state_d = bbc_pkg::S_IDLE;
      end
    endcase
  end

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != bbc_pkg::S_IDLE) |-> !in_ready_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  property p_result_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == bbc_pkg::S_RESULT && !out_ready_i) |=> (state_q == bbc_pkg::S_RESULT);
  endproperty
  a_result_holds: assert property (p_result_holds) else $error("result dropped");

  property p_load_scan;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.load |=> (state_q == bbc_pkg::S_SCAN);
  endproperty
  a_load_scan: assert property (p_load_scan) else $error("load not followed by scan");

endmodule

// ===== rtl/bbc_datapath.sv =====
// ----------------------------------------------------------------------------
// bbc_datapath
// Entry tags, marks, counts and recency ranks with lookup and victim choice.
// ----------------------------------------------------------------------------
module bbc_datapath #(
  parameter int unsigned NUM_BUFFERS = bbc_pkg::NumBuffers,
  parameter int unsigned NUM_DEVICES = bbc_pkg::NumDevices,
  parameter int unsigned REF_BITS    = bbc_pkg::RefBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bbc_pkg::cmd_t cmd_i,
  input  bbc_pkg::req_t req_i,
  output bbc_pkg::sts_t sts_o,
  output bbc_pkg::rsp_t rsp_o
);

  localparam int unsigned RankW     = $clog2(NUM_BUFFERS);
  localparam int unsigned CurW      = $clog2(NUM_BUFFERS + 1);
  localparam int unsigned NumLeaves = 1 << RankW;
  localparam logic [REF_BITS-1:0] RefMax = '1;

  logic [bbc_pkg::DevW-1:0]   tag_dev_q   [NUM_BUFFERS];
  logic [bbc_pkg::BlockW-1:0] tag_blk_q   [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]     mapped_q, valid_q, dirty_q;
  logic [REF_BITS-1:0]        refc_q      [NUM_BUFFERS];
  logic [RankW-1:0]           rank_q      [NUM_BUFFERS];

  bbc_pkg::req_t req_q;
  bbc_pkg::rsp_t rsp_q, rsp_d;

  logic             hit_q, vic_q;
  logic [RankW-1:0] hit_idx_q, vic_idx_q;
  logic [CurW-1:0]  cur_q;
  logic             found_q;
  logic [RankW-1:0] found_idx_q;

  // lookup and victim search
  logic [NUM_BUFFERS-1:0] match, cand;
  logic                   hit_c, vic_c;
  logic [RankW-1:0]       hit_idx_c, vic_idx_c;

  always_comb begin
    hit_c     = 1'b0;
    hit_idx_c = '0;
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      match[i] = mapped_q[i] && (tag_dev_q[i] == req_q.dev) &&
                 (tag_blk_q[i] == req_q.block_number);
      cand[i]  = (refc_q[i] == '0) && !dirty_q[i];
    end
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_c     = 1'b1;
        hit_idx_c = RankW'(i);
      end
    end
  end

  // least recent candidate by a tree of pairwise compares
  logic             tv_ok   [2*NumLeaves];
  logic [RankW-1:0] tv_rank [2*NumLeaves];
  logic [RankW-1:0] tv_idx  [2*NumLeaves];

  always_comb begin
    for (int k = 0; k < 2 * NumLeaves; k++) begin
      tv_ok[k]   = 1'b0;
      tv_rank[k] = '0;
      tv_idx[k]  = '0;
    end
    for (int i = 0; i < NUM_BUFFERS; i++) begin
      tv_ok[NumLeaves + i]   = cand[i];
      tv_rank[NumLeaves + i] = rank_q[i];
      tv_idx[NumLeaves + i]  = RankW'(i);
    end
    for (int k = NumLeaves - 1; k >= 1; k--) begin
      if (tv_ok[2*k] && (!tv_ok[2*k+1] || tv_rank[2*k] <= tv_rank[2*k+1])) begin
        tv_ok[k]   = 1'b1;
        tv_rank[k] = tv_rank[2*k];
        tv_idx[k]  = tv_idx[2*k];
      end else begin
        tv_ok[k]   = tv_ok[2*k+1];
        tv_rank[k] = tv_rank[2*k+1];
        tv_idx[k]  = tv_idx[2*k+1];
      end
    end
  end

  assign vic_c     = tv_ok[1];
  assign vic_idx_c = tv_idx[1];

  // flush search from cursor
  logic             ffound_c;
  logic [RankW-1:0] fidx_c;
  always_comb begin
    ffound_c = 1'b0;
    fidx_c   = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if ((CurW'(i) >= cur_q) && refc_q[i] == '0 && valid_q[i] && dirty_q[i]) begin
        ffound_c = 1'b1;
        fidx_c   = RankW'(i);
      end
    end
  end

  logic dev_ok, idx_ok;
  logic [RankW-1:0] e;
  assign dev_ok = 32'(req_q.dev) < NUM_DEVICES;
  assign idx_ok = (bbc_pkg::IdxW + 1)'(req_q.entry_index) <
                  (bbc_pkg::IdxW + 1)'(NUM_BUFFERS);
  assign e      = RankW'(req_q.entry_index);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mapped_q <= '0;
      valid_q  <= '0;
      dirty_q  <= '0;
      cur_q    <= '0;
      found_q  <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_dev_q[i] <= '0;
        tag_blk_q[i] <= '0;
        refc_q[i]    <= '0;
        rank_q[i]    <= RankW'(i);
      end
    end else begin
      if (cmd_i.load) begin
        cur_q <= '0;
      end
      if (cmd_i.flush_find) begin
        found_q <= ffound_c;
      end
      if (cmd_i.flush_take) begin
        dirty_q[found_idx_q] <= 1'b0;
        cur_q                <= CurW'(found_idx_q) + CurW'(1);
      end
      if (cmd_i.apply) begin
        unique case (bbc_pkg::func_e'(req_q.func))
          bbc_pkg::FUNC_GET: begin
            if (dev_ok && hit_q) begin
              if (refc_q[hit_idx_q] != RefMax) begin
                refc_q[hit_idx_q] <= refc_q[hit_idx_q] + REF_BITS'(1);
              end
              valid_q[hit_idx_q] <= 1'b1;
            end else if (dev_ok && vic_q) begin
              tag_dev_q[vic_idx_q] <= req_q.dev;
              tag_blk_q[vic_idx_q] <= req_q.block_number;
              mapped_q[vic_idx_q]  <= 1'b1;
              valid_q[vic_idx_q]   <= 1'b1;
              dirty_q[vic_idx_q]   <= 1'b0;
              refc_q[vic_idx_q]    <= REF_BITS'(1);
            end
          end
          bbc_pkg::FUNC_RELEASE: begin
            if (idx_ok && refc_q[e] != '0) begin
              refc_q[e] <= refc_q[e] - REF_BITS'(1);
              if (refc_q[e] == REF_BITS'(1)) begin
                for (int i = 0; i < NUM_BUFFERS; i++) begin
                  if (rank_q[i] > rank_q[e]) begin
                    rank_q[i] <= rank_q[i] - RankW'(1);
                  end
                end
                rank_q[e] <= RankW'(NUM_BUFFERS - 1);
              end
            end
          end
          bbc_pkg::FUNC_DIRTY: begin
            if (idx_ok && mapped_q[e]) begin
              dirty_q[e] <= 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    rsp_d = '0;
    if (cmd_i.apply) begin
      rsp_d.last = 1'b1;
      unique case (bbc_pkg::func_e'(req_q.func))
        bbc_pkg::FUNC_GET: begin
          if (dev_ok && hit_q) begin
            rsp_d.entry_index_out = bbc_pkg::IdxW'(hit_idx_q);
            rsp_d.hit             = 1'b1;
            rsp_d.need_read       = !valid_q[hit_idx_q];
            rsp_d.dev_out         = req_q.dev;
            rsp_d.block_out       = req_q.block_number;
          end else if (dev_ok && vic_q) begin
            rsp_d.entry_index_out = bbc_pkg::IdxW'(vic_idx_q);
            rsp_d.need_read       = 1'b1;
            rsp_d.dev_out         = req_q.dev;
            rsp_d.block_out       = req_q.block_number;
          end else begin
            rsp_d.status = bbc_pkg::ST_NOBUF;
          end
        end
        bbc_pkg::FUNC_RELEASE: begin
          rsp_d.entry_index_out = req_q.entry_index;
          if (!idx_ok) begin
            rsp_d.status = bbc_pkg::ST_UNREF;
          end else begin
            if (refc_q[e] == '0) begin
              rsp_d.status = bbc_pkg::ST_UNREF;
            end
            rsp_d.dev_out   = tag_dev_q[e];
            rsp_d.block_out = tag_blk_q[e];
          end
        end
        bbc_pkg::FUNC_DIRTY: begin
          rsp_d.entry_index_out = req_q.entry_index;
          if (idx_ok) begin
            rsp_d.dev_out   = tag_dev_q[e];
            rsp_d.block_out = tag_blk_q[e];
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.flush_take) begin
      rsp_d.entry_index_out = bbc_pkg::IdxW'(found_idx_q);
      rsp_d.write_back      = 1'b1;
      rsp_d.dev_out         = tag_dev_q[found_idx_q];
      rsp_d.block_out       = tag_blk_q[found_idx_q];
    end
    if (cmd_i.close) begin
      rsp_d.last = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.scan) begin
      hit_q     <= hit_c;
      hit_idx_q <= hit_idx_c;
      vic_q     <= vic_c;
      vic_idx_q <= vic_idx_c;
    end
    if (cmd_i.flush_find) begin
      found_idx_q <= fidx_c;
    end
    if (cmd_i.apply || cmd_i.flush_take || cmd_i.close) begin
      rsp_q <= rsp_d;
    end
  end

  assign sts_o.is_flush    = (req_q.func == bbc_pkg::FUNC_FLUSH);
  assign sts_o.flush_found = found_q;
  assign rsp_o             = rsp_q;

  property p_take_found;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.flush_take |-> (found_q && dirty_q[found_idx_q]);
  endproperty
  a_take_found: assert property (p_take_found) else $error("flush takes clean entry");

  property p_take_cleans;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.flush_take |=> !dirty_q[$past(found_idx_q)];
  endproperty
  a_take_cleans: assert property (p_take_cleans) else $error("flushed entry stays dirty");

  property p_one_cmd;
    @(posedge clk_i) disable iff (!rst_ni)
      $onehot0({cmd_i.load, cmd_i.scan, cmd_i.apply, cmd_i.flush_take, cmd_i.close});
  endproperty
  a_one_cmd: assert property (p_one_cmd) else $error("conflicting commands");

endmodule

// ===== test/bbc_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bbc_checker
// Watches the request and result channels of the buffer cache tag manager,
// works out the expected result items of each accepted request from its own
// copy of the tags, marks, counts and recency order, and compares every
// accepted result item field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module bbc_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  logic          req_ready_i,
  input  bbc_pkg::req_t req_data_i,
  input  logic          rsp_valid_i,
  input  logic          rsp_ready_i,
  input  bbc_pkg::rsp_t rsp_data_i,
  output int            errors_o,
  output int            pending_o
);

  localparam int unsigned NumBuffers = bbc_pkg::NumBuffers;
  localparam int unsigned RefMax     = (1 << bbc_pkg::RefBits) - 1;

  logic [bbc_pkg::DevW-1:0]   tag_dev  [NumBuffers];
  logic [bbc_pkg::BlockW-1:0] tag_blk  [NumBuffers];
  logic                       is_mapped[NumBuffers];
  logic                       is_valid [NumBuffers];
  logic                       is_dirty [NumBuffers];
  int unsigned                refs     [NumBuffers];
  int unsigned                rank     [NumBuffers];

  bbc_pkg::rsp_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic bbc_pkg::rsp_t make_item(bbc_pkg::status_e st, int unsigned idx,
                                              logic h, logic nr, logic wb,
                                              logic [bbc_pkg::DevW-1:0] dv,
                                              logic [bbc_pkg::BlockW-1:0] bl,
                                              logic lst);
    bbc_pkg::rsp_t item;
    item.status          = st;
    item.entry_index_out = bbc_pkg::IdxW'(idx);
    item.hit             = h;
    item.need_read       = nr;
    item.write_back      = wb;
    item.dev_out         = dv;
    item.block_out       = bl;
    item.last            = lst;
    return item;
  endfunction

  task automatic touch_entry(int unsigned e);
    int unsigned r;
    r = rank[e];
    for (int i = 0; i < NumBuffers; i++) begin
      if (rank[i] > r) rank[i]--;
    end
    rank[e] = NumBuffers - 1;
  endtask

  task automatic predict_request(bbc_pkg::req_t r);
    int          found;
    int          victim;
    int unsigned e;
    int          listed;
    found  = -1;
    victim = -1;
    e      = r.entry_index;
    listed = 0;
    case (bbc_pkg::func_e'(r.func))
      bbc_pkg::FUNC_GET: begin
        for (int i = 0; i < NumBuffers; i++) begin
          if (found < 0 && is_mapped[i] && tag_dev[i] == r.dev &&
              tag_blk[i] == r.block_number) found = i;
        end
        if (r.dev >= bbc_pkg::NumDevices) begin
          expected_q.push_back(make_item(bbc_pkg::ST_NOBUF, 0, 0, 0, 0, '0, '0, 1'b1));
        end else if (found >= 0) begin
          expected_q.push_back(make_item(bbc_pkg::ST_OK, found, 1'b1, !is_valid[found], 0,
                                         r.dev, r.block_number, 1'b1));
          if (refs[found] < RefMax) refs[found]++;
          is_valid[found] = 1'b1;
        end else begin
          for (int i = 0; i < NumBuffers; i++) begin
            if (refs[i] == 0 && !is_dirty[i] && (victim < 0 || rank[i] < rank[victim]))
              victim = i;
          end
          if (victim < 0) begin
            expected_q.push_back(make_item(bbc_pkg::ST_NOBUF, 0, 0, 0, 0, '0, '0, 1'b1));
          end else begin
            tag_dev[victim]   = r.dev;
            tag_blk[victim]   = r.block_number;
            is_mapped[victim] = 1'b1;
            is_valid[victim]  = 1'b1;
            is_dirty[victim]  = 1'b0;
            refs[victim]      = 1;
            expected_q.push_back(make_item(bbc_pkg::ST_OK, victim, 1'b0, 1'b1, 0,
                                           r.dev, r.block_number, 1'b1));
          end
        end
      end
      bbc_pkg::FUNC_RELEASE: begin
        if (e >= NumBuffers) begin
          expected_q.push_back(make_item(bbc_pkg::ST_UNREF, e, 0, 0, 0, '0, '0, 1'b1));
        end else if (refs[e] == 0) begin
          expected_q.push_back(make_item(bbc_pkg::ST_UNREF, e, 0, 0, 0, tag_dev[e],
                                         tag_blk[e], 1'b1));
        end else begin
          refs[e]--;
          if (refs[e] == 0) touch_entry(e);
          expected_q.push_back(make_item(bbc_pkg::ST_OK, e, 0, 0, 0, tag_dev[e],
                                         tag_blk[e], 1'b1));
        end
      end
      bbc_pkg::FUNC_DIRTY: begin
        if (e >= NumBuffers) begin
          expected_q.push_back(make_item(bbc_pkg::ST_OK, e, 0, 0, 0, '0, '0, 1'b1));
        end else begin
          if (is_mapped[e]) is_dirty[e] = 1'b1;
          expected_q.push_back(make_item(bbc_pkg::ST_OK, e, 0, 0, 0, tag_dev[e],
                                         tag_blk[e], 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < NumBuffers; i++) begin
          if (listed < NumBuffers && refs[i] == 0 && is_valid[i] && is_dirty[i]) begin
            is_dirty[i] = 1'b0;
            expected_q.push_back(make_item(bbc_pkg::ST_OK, i, 0, 0, 1'b1, tag_dev[i],
                                           tag_blk[i], 1'b0));
            listed++;
          end
        end
        expected_q.push_back(make_item(bbc_pkg::ST_OK, 0, 0, 0, 0, '0, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bbc_pkg::rsp_t exp_item;
    if (!rst_ni) begin
      errors_o <= 0;
      expected_q.delete();
      for (int i = 0; i < NumBuffers; i++) begin
        tag_dev[i]   = '0;
        tag_blk[i]   = '0;
        is_mapped[i] = 1'b0;
        is_valid[i]  = 1'b0;
        is_dirty[i]  = 1'b0;
        refs[i]      = 0;
        rank[i]      = i;
      end
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result item %h", rsp_data_i);
          errors_o <= errors_o + 1;
        end else begin
          exp_item = expected_q.pop_front();
          if (rsp_data_i !== exp_item) begin
            if (errors_o < 10) begin
              $display("mismatch: expected st %0d idx %0d hit %b nr %b wb %b dev %h blk %h last %b",
                       exp_item.status, exp_item.entry_index_out, exp_item.hit,
                       exp_item.need_read, exp_item.write_back, exp_item.dev_out,
                       exp_item.block_out, exp_item.last);
              $display("          actual   st %0d idx %0d hit %b nr %b wb %b dev %h blk %h last %b",
                       rsp_data_i.status, rsp_data_i.entry_index_out, rsp_data_i.hit,
                       rsp_data_i.need_read, rsp_data_i.write_back, rsp_data_i.dev_out,
                       rsp_data_i.block_out, rsp_data_i.last);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
      if (req_valid_i && req_ready_i) predict_request(req_data_i);
    end
  end

endmodule

// ===== test/block_buffer_cache_lru_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// block_buffer_cache_lru_test
// Drives get, release, mark-dirty and flush requests into the buffer cache
// tag manager: a directed opening, a full cache, then random traffic on a
// small pool of blocks under three idling patterns.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_test;

  localparam int MaxCycles = 400000;

  logic clk;
  logic rst_n;
  int   tx_idle;
  int   rx_idle;
  int   cycles = 0;
  int   errors;
  int   pending;
  int   held_q[$];
  logic [bbc_pkg::BlockW-1:0] pool_blk[12];
  logic [bbc_pkg::DevW-1:0]   pool_dev[12];

  bbc_if #(.T(bbc_pkg::req_t)) req_if ();
  bbc_if #(.T(bbc_pkg::rsp_t)) rsp_if ();

  block_buffer_cache_lru u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req   (req_if),
    .rsp   (rsp_if)
  );

  bbc_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_data_i (req_if.data),
    .rsp_valid_i(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready),
    .rsp_data_i (rsp_if.data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  initial begin
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    tx_idle      = 0;
    rx_idle      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) rsp_if.ready <= ($urandom_range(99) >= rx_idle);
  end

  // entries granted to a caller, used to pick sensible releases
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready && rsp_if.data.last &&
        rsp_if.data.status == bbc_pkg::ST_OK && (rsp_if.data.hit || rsp_if.data.need_read))
      held_q.push_back(int'(rsp_if.data.entry_index_out));
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send(bbc_pkg::func_e f, logic [bbc_pkg::DevW-1:0] dv,
                      logic [bbc_pkg::BlockW-1:0] bl, logic [bbc_pkg::IdxW-1:0] e);
    bbc_pkg::req_t r;
    r.func         = f;
    r.dev          = dv;
    r.block_number = bl;
    r.entry_index  = e;
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    if ($urandom_range(99) < tx_idle) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic release_held();
    int k;
    k = $urandom_range(held_q.size() - 1);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, bbc_pkg::IdxW'(held_q[k]));
    held_q.delete(k);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    int pick;
    int k;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      k    = $urandom_range(11);
      if (pick < 45) begin
        send(bbc_pkg::FUNC_GET, pool_dev[k], pool_blk[k], bbc_pkg::IdxW'($urandom));
      end else if (pick < 72 && held_q.size() > 0) begin
        release_held();
      end else if (pick < 75) begin
        send(bbc_pkg::FUNC_RELEASE, bbc_pkg::DevW'($urandom), $urandom,
             bbc_pkg::IdxW'($urandom));
      end else if (pick < 88) begin
        send(bbc_pkg::FUNC_DIRTY, bbc_pkg::DevW'($urandom), $urandom,
             bbc_pkg::IdxW'($urandom_range(15)));
      end else if (pick < 93) begin
        send(bbc_pkg::FUNC_FLUSH, bbc_pkg::DevW'($urandom), $urandom,
             bbc_pkg::IdxW'($urandom));
      end else begin
        send(bbc_pkg::func_e'($urandom_range(3)), bbc_pkg::DevW'($urandom), $urandom,
             bbc_pkg::IdxW'($urandom));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < 12; i++) begin
      pool_dev[i] = bbc_pkg::DevW'($urandom_range(3));
      pool_blk[i] = $urandom_range(20);
    end
    pool_dev[0] = 4'hF;
    pool_blk[0] = 32'hFFFF_FFFF;
    pool_dev[1] = 4'h0;
    pool_blk[1] = 32'h0;
    pool_blk[2] = $urandom;
    pool_blk[3] = ~pool_blk[2];
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed opening
    send(bbc_pkg::FUNC_GET, 4'h0, 32'h0, '0);
    send(bbc_pkg::FUNC_GET, 4'hF, 32'hFFFF_FFFF, '0);
    send(bbc_pkg::FUNC_GET, 4'hF, 32'hFFFF_FFFF, '0);
    send(bbc_pkg::FUNC_GET, 4'hA, 32'h5555_AAAA, 5'd31);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, 5'd1);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, 5'd1);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, 5'd1);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, 5'd31);
    send(bbc_pkg::FUNC_DIRTY, '0, '0, 5'd30);
    send(bbc_pkg::FUNC_DIRTY, '0, '0, 5'd0);
    send(bbc_pkg::FUNC_DIRTY, '0, '0, 5'd1);
    send(bbc_pkg::FUNC_FLUSH, '0, '0, '0);
    send(bbc_pkg::FUNC_RELEASE, '0, '0, 5'd0);
    send(bbc_pkg::FUNC_FLUSH, '0, '0, '0);
    send(bbc_pkg::FUNC_FLUSH, '0, '0, '0);
    send(bbc_pkg::FUNC_GET, 4'h0, 32'h0, '0);
    send(bbc_pkg::FUNC_GET, 4'h5, 32'hAAAA_5555, '0);
    send(bbc_pkg::FUNC_GET, 4'h5, 32'hAAAA_5555, '0);
    drain();
    held_q.delete();

    // fill every entry, dirty them all, then no buffer left
    for (int i = 0; i < 33; i++) send(bbc_pkg::FUNC_GET, 4'h7, 32'h100 + i, '0);
    for (int i = 0; i < 32; i++) send(bbc_pkg::FUNC_DIRTY, '0, '0, bbc_pkg::IdxW'(i));
    drain();
    while (held_q.size() > 0) release_held();
    send(bbc_pkg::FUNC_GET, 4'h8, 32'h1, '0);
    send(bbc_pkg::FUNC_FLUSH, '0, '0, '0);
    send(bbc_pkg::FUNC_GET, 4'h8, 32'h1, '0);
    drain();

    tx_idle = 30;
    rx_idle = 61;
    random_phase(55);
    drain();
    tx_idle = 61;
    rx_idle = 30;
    random_phase(55);
    drain();
    tx_idle = 0;
    rx_idle = 0;
    random_phase(50);
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
